// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

// ===== rtl/core/asa_pkg.sv =====
// ----------------------------------------------------------------------------
// asa_pkg
// Types and constants of the adaptive sample averager.
// ----------------------------------------------------------------------------
`default_nettype none
package asa_pkg;
  localparam logic [15:0] W_RED   = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE  = 16'd4732;
  localparam logic [1:0] CFG_MAX = 2'd0;
  localparam logic [1:0] CFG_MIN = 2'd1;
  localparam logic [1:0] CFG_THR = 2'd2;
  localparam logic [1:0] CFG_ADP = 2'd3;
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_CONV = 2'd1;
  localparam logic [1:0] CAUSE_MAX  = 2'd2;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] luma;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MDIV, ST_MUL, ST_ACC, ST_BND1, ST_BND2, ST_DEC, ST_ADIV, ST_OUT
  } back_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/asa_front.sv =====
// ----------------------------------------------------------------------------
// asa_front
// Accepts samples, computes luminance and holds a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module asa_front import asa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] sample_red,
  input  wire logic [15:0] sample_green,
  input  wire logic [15:0] sample_blue,
  output logic             q_valid,
  input  wire logic        q_ready,
  output item_t            q_item
);
  item_t       mem [2];
  logic        wp, rp;
  logic [1:0]  cnt;
  logic [31:0] wsum;
  logic        push, pop;

  assign wsum = 32'(W_RED) * 32'(sample_red) + 32'(W_GREEN) * 32'(sample_green)
              + 32'(W_BLUE) * 32'(sample_blue);
  assign in_ready = (cnt != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= '{sample_red, sample_green, sample_blue, wsum[31:16]};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/asa_div.sv =====
// ----------------------------------------------------------------------------
// asa_div
// Restoring divider, one quotient bit a cycle, unsigned 33 by 11.
// ----------------------------------------------------------------------------
`default_nettype none
module asa_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] dividend,
  input  wire logic [10:0] divisor,
  output logic             busy,
  output logic [32:0] quotient
);
  logic [10:0] rem;
  logic [5:0]  bits;
  logic [11:0] trial;

  assign trial = {rem, quotient[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bits <= '0;
    end else if (start) begin
      busy <= 1'b1;
      bits <= 6'd33;
    end else if (busy) begin
      bits <= bits - 6'd1;
      if (bits == 6'd1) busy <= 1'b0;
    end
    if (start) begin
      rem <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= 11'(trial - {1'b0, divisor});
        quotient <= {quotient[31:0], 1'b1};
      end else begin
        rem <= trial[10:0];
        quotient <= {quotient[31:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/asa_back.sv =====
// ----------------------------------------------------------------------------
// asa_back
// Accumulates, runs the Welford update in adaptive mode and the stop test, emits a result.
// ----------------------------------------------------------------------------
`default_nettype none
module asa_back import asa_pkg::*; #(
  parameter int SAMPLE_LIMIT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  item_t            q_item,
  input  wire logic [10:0] max_samples,
  input  wire logic [10:0] min_samples,
  input  wire logic [15:0] threshold,
  input  wire logic        adaptive_enable,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pixel_done,
  output logic [15:0]      avg_red,
  output logic [15:0]      avg_green,
  output logic [15:0]      avg_blue,
  output logic [10:0]      samples_used,
  output logic [1:0]       stop_cause
);
  localparam int CAP = (SAMPLE_LIMIT < 1024) ? SAMPLE_LIMIT : 1024;
  localparam logic [10:0] CAP_V = 11'(CAP);

  back_state_t state, state_next;
  logic [25:0] red_sum, green_sum, blue_sum;
  logic [10:0] sample_count;
  logic [31:0] mean;
  logic [63:0] m2;
  logic [15:0] luma;
  logic [32:0] a1, a2;
  logic        neg;
  logic [63:0] prod;
  logic [63:0] bound;
  logic [31:0] thr2;
  logic [21:0] nn1;
  logic        ad;
  logic [1:0]  cause;
  logic [1:0]  ch;
  logic [15:0] avg [3];
  logic [10:0] max_eff, min_eff;
  logic        d_start, d_busy;
  logic [32:0] d_dividend, d_q;
  logic [32:0] yq;
  logic [32:0] delta;
  logic [32:0] newmean;
  logic [64:0] m2sum;

  assign max_eff = (max_samples == 11'd0) ? 11'd1 :
                   (max_samples > CAP_V) ? CAP_V : max_samples;
  assign min_eff = (min_samples == 11'd0) ? 11'd1 :
                   (min_samples > max_eff) ? max_eff : min_samples;
  assign yq = {1'b0, luma, 16'd0};
  assign delta = yq - {1'b0, mean};
  assign newmean = neg ? ({1'b0, mean} - d_q) : ({1'b0, mean} + d_q);
  assign m2sum = {1'b0, m2} + {33'd0, prod[63:32]};

  asa_div u_div (
    .clk(clk), .rst(rst), .start(d_start), .dividend(d_dividend),
    .divisor(sample_count), .busy(d_busy), .quotient(d_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    d_start = 1'b0;
    d_dividend = delta[32] ? (~delta + 33'd1) : delta;
    case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = ST_DEC;
      end
      ST_DEC: begin
        if (ad) begin
          d_start = 1'b1;
          state_next = ST_MDIV;
        end else begin
          state_next = ST_BND2;
        end
      end
      ST_MDIV: if (!d_busy) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = ST_BND1;
      ST_BND1: state_next = ST_BND2;
      ST_BND2: begin
        if (cause != CAUSE_NONE) begin
          d_start = 1'b1;
          d_dividend = {7'd0, red_sum};
          state_next = ST_ADIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_ADIV: begin
        d_dividend = (ch == 2'd0) ? {7'd0, green_sum} : {7'd0, blue_sum};
        if (!d_busy && ch == 2'd2) state_next = ST_OUT;
        else if (!d_busy) d_start = 1'b1;
      end
      ST_OUT: if (!out_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      red_sum <= '0; green_sum <= '0; blue_sum <= '0;
      sample_count <= '0; mean <= '0; m2 <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (q_valid) begin
          red_sum <= red_sum + 26'(q_item.red);
          green_sum <= green_sum + 26'(q_item.green);
          blue_sum <= blue_sum + 26'(q_item.blue);
          sample_count <= sample_count + 11'd1;
          luma <= q_item.luma;
          ad <= adaptive_enable;
          cause <= CAUSE_NONE;
          ch <= 2'd0;
        end
        ST_DEC: begin
          neg <= delta[32];
          a1 <= delta[32] ? (~delta + 33'd1) : delta;
          if (!ad && sample_count >= max_eff) cause <= CAUSE_MAX;
        end
        ST_MDIV: if (!d_busy) begin
          mean <= newmean[31:0];
          a2 <= (yq >= {1'b0, newmean[31:0]}) ? yq - {1'b0, newmean[31:0]}
                                               : {1'b0, newmean[31:0]} - yq;
          thr2 <= 32'(threshold) * 32'(threshold);
          nn1 <= 22'(sample_count) * 22'(sample_count - 11'd1);
        end
        ST_MUL: begin
          prod <= 64'(a1) * 64'(a2);
          bound <= 64'(thr2) * 64'(nn1);
        end
        ST_ACC: m2 <= m2sum[64] ? '1 : m2sum[63:0];
        ST_BND1: begin
          if (sample_count >= min_eff && sample_count > 11'd1 && m2 < bound)
            cause <= CAUSE_CONV;
          else if (sample_count >= max_eff) cause <= CAUSE_MAX;
        end
        ST_BND2: begin
          avg[0] <= '0; avg[1] <= '0; avg[2] <= '0;
        end
        ST_ADIV: if (!d_busy && state_next == ST_ADIV) begin
          avg[ch] <= d_q[15:0];
          ch <= ch + 2'd1;
        end else if (!d_busy) begin
          avg[2] <= d_q[15:0];
        end
        ST_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          pixel_done <= (cause != CAUSE_NONE);
          avg_red <= avg[0];
          avg_green <= avg[1];
          avg_blue <= avg[2];
          samples_used <= sample_count;
          stop_cause <= cause;
          if (cause != CAUSE_NONE) begin
            red_sum <= '0; green_sum <= '0; blue_sum <= '0;
            sample_count <= '0; mean <= '0; m2 <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/adaptive_sample_averager_unit.sv =====
// ----------------------------------------------------------------------------
// adaptive_sample_averager_unit
// Per-pixel sample averager with Welford luminance convergence stop.
// ----------------------------------------------------------------------------
// channel | signals                               | direction
// sample  | in_valid/in_ready, sample_*           | in
// config  | cfg_valid/cfg_ready, cfg_index/data   | in
// result  | out_valid/out_ready, pixel_done...    | out
// Continuing sample in adaptive mode: runs the serial mean divider; with
// adaptive mode off the divider is skipped.
// Stopping sample: three more divider runs follow, for the averages.
// Two-entry queue takes samples while the back end works. Reset is synchronous.
// A stalled result holds the back end; the queue still fills.
`default_nettype none
module adaptive_sample_averager_unit import asa_pkg::*; #(
  parameter int SAMPLE_LIMIT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] sample_red,
  input  wire logic [15:0] sample_green,
  input  wire logic [15:0] sample_blue,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             pixel_done,
  output logic [15:0]      avg_red,
  output logic [15:0]      avg_green,
  output logic [15:0]      avg_blue,
  output logic [10:0]      samples_used,
  output logic [1:0]       stop_cause
);
  logic [10:0] max_samples, min_samples;
  logic [15:0] threshold;
  logic        adaptive_enable;
  logic        q_valid, q_ready;
  item_t       q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_samples <= 11'd16;
      min_samples <= 11'd4;
      threshold <= '0;
      adaptive_enable <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX: max_samples <= cfg_data[10:0];
        CFG_MIN: min_samples <= cfg_data[10:0];
        CFG_THR: threshold <= cfg_data;
        CFG_ADP: adaptive_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  asa_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sample_red(sample_red), .sample_green(sample_green), .sample_blue(sample_blue),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  asa_back #(.SAMPLE_LIMIT(SAMPLE_LIMIT)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .max_samples(max_samples), .min_samples(min_samples), .threshold(threshold),
    .adaptive_enable(adaptive_enable), .out_valid(out_valid), .out_ready(out_ready),
    .pixel_done(pixel_done), .avg_red(avg_red), .avg_green(avg_green),
    .avg_blue(avg_blue), .samples_used(samples_used), .stop_cause(stop_cause)
  );
endmodule
`default_nettype wire

// ===== rtl/core/asa_checker.sv =====
// ----------------------------------------------------------------------------
// asa_checker
// Port-level checks of the averager.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module asa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        pixel_done,
  input wire logic [1:0]  stop_cause,
  input wire logic [15:0] avg_red,
  input wire logic [10:0] samples_used
);
  `CHK_IMPL(done_cause, clk, rst, out_valid, pixel_done == (stop_cause != 2'd0))
  `CHK_IMPL(idle_zero, clk, rst, out_valid && !pixel_done, avg_red == 16'd0)
  `CHK_IMPL(count_nz, clk, rst, out_valid, samples_used != 11'd0)
  `CHK_NEXT(hold_out, clk, rst, out_valid && !out_ready, out_valid && $stable(samples_used))
endmodule
bind adaptive_sample_averager_unit asa_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .pixel_done(pixel_done), .stop_cause(stop_cause), .avg_red(avg_red),
  .samples_used(samples_used)
);
`default_nettype wire
